### rtl/bhe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhe_pkg: shared types and constants of the byte histogram core
// Command and result words, internal operation codes and sequencer states.
// ----------------------------------------------------------------------------
package bhe_pkg;

	localparam int BYTE_W   = 8;
	localparam int RCOUNT_W = 32;
	localparam int PHASE_W  = 2;
	localparam int MODE_W   = 2;

	// Register index of channel_mode in the configuration map.
	localparam int REG_CHANNEL_MODE = 0;

	// channel_mode code that counts every byte.
	localparam logic [MODE_W-1:0] MODE_ALL = 2'd0;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_SCAN  = 2'd3
	} bhe_cmd_t;

	typedef struct packed {
		bhe_cmd_t            cmd;
		logic [BYTE_W-1:0]   sample_byte;
		logic [BYTE_W-1:0]   bin_index;
	} bhe_word_in_t;

	typedef struct packed {
		logic [RCOUNT_W-1:0] bin_count;
		logic [BYTE_W-1:0]   max_value;
		logic [RCOUNT_W-1:0] max_count;
		logic [BYTE_W-1:0]   min_value;
		logic [RCOUNT_W-1:0] min_count;
	} bhe_result_t;

	// Operations handed from the front end to the back end.
	typedef enum logic [2:0] {
		OP_NOP   = 3'd0,
		OP_ADD   = 3'd1,
		OP_READ  = 3'd2,
		OP_SCAN  = 3'd3,
		OP_CLEAR = 3'd4
	} bhe_op_t;

	typedef enum logic [1:0] {
		ST_INIT  = 2'd0,
		ST_RUN   = 2'd1,
		ST_CLEAR = 2'd2,
		ST_SCAN  = 2'd3
	} bhe_state_t;

endpackage

### rtl/bhe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhe_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bhe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/bhe_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhe_fifo: small register queue
// First-word-fall-through queue with occupancy count.
// ----------------------------------------------------------------------------
module bhe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty,
	output logic [CW-1:0]    count
);

	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign count    = cnt_q;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/bhe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhe_front: command intake and classification
// Tracks the color component phase and turns each command word into an
// operation for the back end.
// ----------------------------------------------------------------------------
module bhe_front #(
	parameter int NUM_BINS = 256,
	parameter int BYTES_PER_PIXEL = 3,
	localparam int ADDR_W = $clog2(NUM_BINS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  bhe_pkg::bhe_word_in_t               cmd_word,
	input  logic [bhe_pkg::MODE_W-1:0]          channel_mode,
	input  logic                                init_busy,
	input  logic                                q_full,
	output logic                                q_push,
	output bhe_pkg::bhe_op_t                    op_kind,
	output logic [ADDR_W-1:0]                   op_addr
);

	import bhe_pkg::*;

	localparam int CMP_W = ((ADDR_W > BYTE_W) ? ADDR_W : BYTE_W) + 1;
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(BYTES_PER_PIXEL - 1);

	logic [PHASE_W-1:0] phase_q;
	logic               take, sample_in, index_in;

	assign cmd_ready = !q_full && !init_busy;
	assign q_push    = cmd_valid && cmd_ready;

	assign take      = (channel_mode == MODE_ALL) || (phase_q == channel_mode - 2'd1);
	assign sample_in = CMP_W'(cmd_word.sample_byte) < CMP_W'(NUM_BINS);
	assign index_in  = CMP_W'(cmd_word.bin_index) < CMP_W'(NUM_BINS);

	always_comb begin
		op_kind = OP_NOP;
		op_addr = ADDR_W'(cmd_word.sample_byte);
		case (cmd_word.cmd)
			CMD_CLEAR: begin
				op_kind = OP_CLEAR;
			end
			CMD_ADD: begin
				op_kind = (take && sample_in) ? OP_ADD : OP_NOP;
			end
			CMD_READ: begin
				op_kind = index_in ? OP_READ : OP_NOP;
				op_addr = ADDR_W'(cmd_word.bin_index);
			end
			CMD_SCAN: begin
				op_kind = OP_SCAN;
			end
			default: begin
				op_kind = OP_NOP;
			end
		endcase
	end

	// The phase moves on every add, counted or not, and restarts on clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (q_push) begin
			if (cmd_word.cmd == CMD_CLEAR) begin
				phase_q <= '0;
			end else if (cmd_word.cmd == CMD_ADD) begin
				phase_q <= (phase_q == PHASE_LAST) ? '0 : phase_q + 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_LAST)
		else $error("component phase left the pixel");
`endif

endmodule

### rtl/bhe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhe_back: histogram execution engine
// Owns the bin memory, performs increments, reads, clears and the extremes
// scan, and buffers result words.
// ----------------------------------------------------------------------------
module bhe_back #(
	parameter int NUM_BINS = 256,
	parameter int COUNT_BITS = 32,
	localparam int ADDR_W = $clog2(NUM_BINS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  op_valid,
	input  bhe_pkg::bhe_op_t      op_kind,
	input  logic [ADDR_W-1:0]     op_addr,
	output logic                  op_pop,
	output logic                  init_busy,
	output logic                  res_valid,
	input  logic                  res_ready,
	output bhe_pkg::bhe_result_t  res_word
);

	import bhe_pkg::*;

	localparam int OUT_DEPTH = 4;
	localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);
	localparam int RES_W     = $bits(bhe_result_t);
	localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(NUM_BINS - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	bhe_state_t state_q, state_d;
	logic [ADDR_W-1:0] ptr_q, ptr_d;

	// Read pipeline stage: memory data is valid here.
	logic              op_v_s1;
	bhe_op_t           kind_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              last_s1;

	// Last write, for a read that hit the same edge.
	logic                  fwd_v_q;
	logic [ADDR_W-1:0]     fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	logic [COUNT_BITS-1:0] hi_q, lo_q, hi_d, lo_d;
	logic [ADDR_W-1:0]     hi_at_q, lo_at_q, hi_at_d, lo_at_d;

	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr, rd_addr;
	logic [COUNT_BITS-1:0] wr_data, ram_rdata, rd_data;

	logic                  res_push, res_empty, room, drain_ok, is_ctl;
	logic [OCNT_W-1:0]     res_count;
	bhe_result_t           res_d;
	logic [RES_W-1:0]      res_pop_data;

	bhe_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_bins (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	bhe_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_res_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_d),
		.pop       (res_valid && res_ready),
		.pop_data  (res_pop_data),
		.full      (),
		.empty     (res_empty),
		.count     (res_count)
	);

	assign res_valid = !res_empty;
	assign res_word  = bhe_result_t'(res_pop_data);
	assign init_busy = (state_q == ST_INIT);

	// Every operation in the read stage may push one result, so it holds a slot.
	assign room     = ((OCNT_W + 1)'(res_count) + (OCNT_W + 1)'(op_v_s1))
		< (OCNT_W + 1)'(OUT_DEPTH);
	assign is_ctl   = (op_kind == OP_SCAN) || (op_kind == OP_CLEAR);
	assign drain_ok = !op_v_s1 || !is_ctl;
	assign op_pop   = op_valid && (state_q == ST_RUN) && room && drain_ok;
	assign rd_addr  = (state_q == ST_SCAN) ? ptr_q : op_addr;

	assign rd_data = (fwd_v_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : ram_rdata;

	// Running extremes; the first bin seeds both, ties keep the lower index.
	always_comb begin
		hi_d    = hi_q;
		lo_d    = lo_q;
		hi_at_d = hi_at_q;
		lo_at_d = lo_at_q;
		if (addr_s1 == '0) begin
			hi_d    = rd_data;
			lo_d    = rd_data;
			hi_at_d = '0;
			lo_at_d = '0;
		end else begin
			if (rd_data > hi_q) begin
				hi_d    = rd_data;
				hi_at_d = addr_s1;
			end
			if (rd_data < lo_q) begin
				lo_d    = rd_data;
				lo_at_d = addr_s1;
			end
		end
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = addr_s1;
		wr_data  = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
		res_push = 1'b0;
		res_d    = '0;
		if (op_v_s1) begin
			case (kind_s1)
				OP_ADD: begin
					wr_en    = 1'b1;
					res_push = 1'b1;
				end
				OP_READ: begin
					res_push        = 1'b1;
					res_d.bin_count = RCOUNT_W'(rd_data);
				end
				OP_SCAN: begin
					res_push        = last_s1;
					res_d.max_value = BYTE_W'(hi_at_d);
					res_d.max_count = RCOUNT_W'(hi_d);
					res_d.min_value = BYTE_W'(lo_at_d);
					res_d.min_count = RCOUNT_W'(lo_d);
				end
				default: begin
					res_push = 1'b1;
				end
			endcase
		end
		if (op_pop && (op_kind == OP_CLEAR)) begin
			res_push = 1'b1;
		end
		if ((state_q == ST_INIT) || (state_q == ST_CLEAR)) begin
			wr_en   = 1'b1;
			wr_addr = ptr_q;
			wr_data = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		ptr_d   = ptr_q;
		case (state_q)
			ST_INIT, ST_CLEAR, ST_SCAN: begin
				if (ptr_q == LAST_ADDR) begin
					state_d = ST_RUN;
					ptr_d   = '0;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_RUN: begin
				if (op_pop && (op_kind == OP_CLEAR)) begin
					state_d = ST_CLEAR;
				end else if (op_pop && (op_kind == OP_SCAN)) begin
					state_d = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_INIT;
				ptr_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_v_s1 <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			op_v_s1 <= (op_pop && !is_ctl) || (state_q == ST_SCAN);
			fwd_v_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1    <= (state_q == ST_SCAN) ? OP_SCAN : op_kind;
		addr_s1    <= rd_addr;
		last_s1    <= (ptr_q == LAST_ADDR);
		fwd_addr_q <= wr_addr;
		fwd_data_q <= wr_data;
		if (op_v_s1 && (kind_s1 == OP_SCAN)) begin
			hi_q    <= hi_d;
			lo_q    <= lo_d;
			hi_at_q <= hi_at_d;
			lo_at_q <= lo_at_d;
		end
	end

`ifndef ASSERT_OFF
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !wr_en)
		else $error("bin written during extremes scan");
`endif

`ifndef ASSERT_OFF
	a_sweep_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_INIT) || (state_q == ST_CLEAR)) |-> !op_pop)
		else $error("operation taken during clearing sweep");
`endif

`ifndef ASSERT_OFF
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_count != OCNT_W'(OUT_DEPTH)))
		else $error("result pushed into a full queue");
`endif

endmodule

### rtl/byte_histogram_with_extremes_core.sv
// Path: each command word passes the operation queue, the back end and its result queue.
// Throughput: one add or read per cycle, set by the bin memory read-increment-write loop,
// while the result queue has room and no sweep runs. Clear sweeps one bin a cycle;
// the scan reads every bin. Reset sweeps the bins to zero, no word is taken meanwhile.
// Reset sets channel_mode and the component phase to zero.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_histogram_with_extremes_core: 256-bin byte histogram with extremes
// Counts pixel bytes or one BGR component into saturating bins, reads bins
// back and finds the most and least frequent value.
// ----------------------------------------------------------------------------
module byte_histogram_with_extremes_core #(
	parameter int NUM_BINS = 256,
	parameter int COUNT_BITS = 32,
	parameter int BYTES_PER_PIXEL = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Command words.
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  bhe_pkg::bhe_word_in_t cmd_word,
	// Result words, one for every command word.
	output logic                  res_valid,
	input  logic                  res_ready,
	output bhe_pkg::bhe_result_t  res_word,
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	import bhe_pkg::*;

	localparam int ADDR_W   = $clog2(NUM_BINS);
	localparam int PADDR_W  = 3;
	localparam int OP_DEPTH = 4;
	localparam int OP_W     = $bits(bhe_op_t) + ADDR_W;

	// The front end classifies command words into operations and tracks the
	// color component phase. A short operation queue decouples it from the
	// back end, which owns the bin memory and holds its own result queue.

	logic [MODE_W-1:0] channel_mode_q;
	logic              reg_sel, init_busy;
	logic              q_full, q_empty, q_push, op_pop;
	bhe_op_t           fe_kind;
	logic [ADDR_W-1:0] fe_addr;
	logic [OP_W-1:0]   q_head;

	// Register access. Only channel_mode is implemented; the register is
	// written in the access phase and reads return its value.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == (PADDR_W - 2)'(REG_CHANNEL_MODE));
	assign prdata  = (psel && reg_sel) ? 32'(channel_mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_mode_q <= MODE_ALL;
		end else if (psel && penable && pwrite && reg_sel) begin
			channel_mode_q <= pwdata[MODE_W-1:0];
		end
	end

	bhe_front #(
		.NUM_BINS        (NUM_BINS),
		.BYTES_PER_PIXEL (BYTES_PER_PIXEL)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd_word     (cmd_word),
		.channel_mode (channel_mode_q),
		.init_busy    (init_busy),
		.q_full       (q_full),
		.q_push       (q_push),
		.op_kind      (fe_kind),
		.op_addr      (fe_addr)
	);

	// Operation queue between the two halves.
	bhe_fifo #(.WIDTH(OP_W), .DEPTH(OP_DEPTH)) u_op_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({fe_kind, fe_addr}),
		.pop       (op_pop),
		.pop_data  (q_head),
		.full      (q_full),
		.empty     (q_empty),
		.count     ()
	);

	bhe_back #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (!q_empty),
		.op_kind   (bhe_op_t'(q_head[OP_W-1:ADDR_W])),
		.op_addr   (q_head[ADDR_W-1:0]),
		.op_pop    (op_pop),
		.init_busy (init_busy),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

endmodule

### tb/sv/byte_histogram_with_extremes_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_histogram_with_extremes_core_test: self-checking bench for the core
// Drives command words through the valid/ready port and sets channel_mode
// over the register port. Every result word is compared field by field
// against an in-bench histogram of bins, component phase and mode, or a typed
// value for pinned words. A short list of directed words comes first, then
// random traffic in every channel mode, with random stalls on both sides.
// ----------------------------------------------------------------------------
module byte_histogram_with_extremes_core_test;

	import bhe_pkg::*;

	localparam int          HIST_BINS     = 256;
	localparam int          PIXEL_BYTES   = 3;
	// Longest stretch of work that gives no result word: the sweep of a clear
	// or of a scan, plus the pipeline. Used before register writes and at the end.
	localparam int          SETTLE_CYCLES = 300;
	localparam int          RX_HOLD_CYCLES = 300;
	localparam logic [2:0]  MODE_ADDR     = 3'(4 * REG_CHANNEL_MODE);
	localparam logic [1:0]  MODE_BLUE     = 2'd1;
	localparam logic [1:0]  MODE_GREEN    = 2'd2;
	localparam logic [1:0]  MODE_RED      = 2'd3;

	// One directed command word; when pinned is set, the result is the typed
	// value instead of the one the histogram model works out.
	typedef struct {
		bhe_word_in_t word;
		bit           pinned;
		bhe_result_t  result;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         cmd_valid;
	logic         cmd_ready;
	bhe_word_in_t cmd_word;
	logic         res_valid;
	logic         res_ready;
	bhe_result_t  res_word;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	// Travel with cmd_word, so the checker sees them at the same edge.
	bit           word_pinned;
	bhe_result_t  word_pinned_res;

	// Histogram model state: bins, component phase and channel_mode.
	logic [RCOUNT_W-1:0] hist [HIST_BINS] = '{default: '0};
	logic [PHASE_W-1:0]  pix_phase = '0;
	logic [MODE_W-1:0]   mode_m = MODE_ALL;

	bhe_result_t pending_results [$];
	int          words_sent  = 0;
	int          words_taken = 0;
	int          n_errors    = 0;
	int          n_by_cmd [4] = '{default: 0};
	bit          quiet       = 1'b0;
	dir_row_t    dir_rows [$];

	byte_histogram_with_extremes_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_word (cmd_word),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_word (res_word),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the core hangs; far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("Timeout: the run did not finish in time.");
		$display("CHECKS FAILED");
		$finish;
	end

	// One line per mismatch; printing is capped so a broken core cannot
	// flood the log, but every mismatch is counted.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		if (n_errors <= 30) begin
			$display("MISMATCH at result %0d, %s: got %0h, want %0h",
				words_taken, what, got, want);
		end
	endtask

	// Applies one command word to the histogram model and gives the result
	// word the core must return for it.
	task automatic hist_apply(input bhe_word_in_t w, output bhe_result_t r);
		logic [RCOUNT_W-1:0] top;
		logic [RCOUNT_W-1:0] low;
		int                  top_at;
		int                  low_at;
		r = '0;
		case (w.cmd)
			CMD_CLEAR: begin
				foreach (hist[i]) hist[i] = '0;
				pix_phase = '0;
			end
			CMD_ADD: begin
				// In a component mode only the byte whose phase matches the
				// selected component is counted; the phase always moves on.
				if ((mode_m == MODE_ALL || pix_phase == PHASE_W'(mode_m - 1'b1)) &&
						hist[w.sample_byte] != '1) begin
					hist[w.sample_byte] = hist[w.sample_byte] + 1'b1;
				end
				pix_phase = (pix_phase == PHASE_W'(PIXEL_BYTES - 1)) ? '0 : pix_phase + 1'b1;
			end
			CMD_READ: begin
				r.bin_count = hist[w.bin_index];
			end
			CMD_SCAN: begin
				top    = hist[0];
				low    = hist[0];
				top_at = 0;
				low_at = 0;
				// Strict compares keep the lowest index on ties.
				for (int i = 1; i < HIST_BINS; i++) begin
					if (hist[i] > top) begin
						top    = hist[i];
						top_at = i;
					end
					if (hist[i] < low) begin
						low    = hist[i];
						low_at = i;
					end
				end
				r.max_value = BYTE_W'(top_at);
				r.max_count = top;
				r.min_value = BYTE_W'(low_at);
				r.min_count = low;
			end
			default: ;
		endcase
	endtask

	// Checker: accepted command words feed the model first, then accepted
	// result words are compared with the oldest pending expectation. Register
	// writes update the model's copy of channel_mode at the write edge.
	always @(posedge clk) begin : result_check
		bhe_result_t want;
		bhe_result_t got;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == MODE_ADDR) begin
				mode_m = pwdata[MODE_W-1:0];
			end
			if (cmd_valid && cmd_ready) begin
				hist_apply(cmd_word, want);
				if (word_pinned) begin
					want = word_pinned_res;
				end
				pending_results.push_back(want);
				n_by_cmd[cmd_word.cmd]++;
			end
			if (res_valid && res_ready) begin
				got = res_word;
				if (pending_results.size() == 0) begin
					report_mismatch("result word with nothing pending", got.bin_count, 0);
				end else begin
					want = pending_results.pop_front();
					if (got.bin_count !== want.bin_count)
						report_mismatch("bin_count", got.bin_count, want.bin_count);
					if (got.max_value !== want.max_value)
						report_mismatch("max_value", 32'(got.max_value), 32'(want.max_value));
					if (got.max_count !== want.max_count)
						report_mismatch("max_count", got.max_count, want.max_count);
					if (got.min_value !== want.min_value)
						report_mismatch("min_value", 32'(got.min_value), 32'(want.min_value));
					if (got.min_count !== want.min_count)
						report_mismatch("min_count", got.min_count, want.min_count);
				end
				words_taken++;
			end
		end
	end

	// Result side. Random stall bursts, except once: after a few hundred
	// results the receiver holds off for a long stretch so the core backs up
	// and stalls its command port while the sender keeps offering words.
	initial begin : receiver
		bit held;
		held      = 1'b0;
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && words_taken >= 340) begin
				held = 1'b1;
				res_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				res_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				res_ready <= 1'b1;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	function automatic bhe_word_in_t mk_word(bhe_cmd_t c, logic [7:0] s, logic [7:0] b);
		bhe_word_in_t w;
		w.cmd         = c;
		w.sample_byte = s;
		w.bin_index   = b;
		return w;
	endfunction

	function automatic bhe_result_t mk_res(logic [31:0] bc, logic [7:0] maxv,
			logic [31:0] maxc, logic [7:0] minv, logic [31:0] minc);
		bhe_result_t r;
		r.bin_count = bc;
		r.max_value = maxv;
		r.max_count = maxc;
		r.min_value = minv;
		r.min_count = minc;
		return r;
	endfunction

	function automatic dir_row_t row_pinned(bhe_word_in_t w, bhe_result_t r);
		dir_row_t d;
		d.word   = w;
		d.pinned = 1'b1;
		d.result = r;
		return d;
	endfunction

	function automatic dir_row_t row_model(bhe_word_in_t w);
		dir_row_t d;
		d.word   = w;
		d.pinned = 1'b0;
		d.result = '0;
		return d;
	endfunction

	// Random command word. Adds dominate so bins build up; bytes are often
	// drawn from a narrow range to give clear maxima, sometimes from the two
	// ends, and otherwise from the full range so every bit toggles. Scans are
	// kept fairly rare because each one sweeps all bins.
	function automatic bhe_word_in_t random_word();
		bhe_word_in_t w;
		int           pick;
		int           how;
		pick = $urandom_range(0, 99);
		if (pick < 3)       w.cmd = CMD_CLEAR;
		else if (pick < 68) w.cmd = CMD_ADD;
		else if (pick < 90) w.cmd = CMD_READ;
		else                w.cmd = CMD_SCAN;
		how = $urandom_range(0, 3);
		if (how < 2)       w.sample_byte = 8'($urandom_range(0, 15));
		else if (how == 2) w.sample_byte = 8'($urandom_range(0, 255));
		else               w.sample_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 1)) w.bin_index = 8'($urandom_range(0, 15));
		else                      w.bin_index = 8'($urandom_range(0, 255));
		return w;
	endfunction

	// Offers one word and returns at the edge where it is taken. Valid stays
	// high into the next word unless a random gap follows.
	task automatic send_word(input bhe_word_in_t w, input bit pinned, input bhe_result_t r);
		cmd_word        <= w;
		cmd_valid       <= 1'b1;
		word_pinned     <= pinned;
		word_pinned_res <= r;
		do @(posedge clk); while (!cmd_ready);
		words_sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			send_word(random_word(), 1'b0, '0);
		end
	endtask

	// Stops offering words and waits until every result word is back.
	task automatic drain();
		cmd_valid <= 1'b0;
		while (words_taken != words_sent) @(posedge clk);
	endtask

	// Writes channel_mode once the core is idle, then reads it back.
	task automatic set_mode(input logic [MODE_W-1:0] m);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MODE_ADDR;
		pwdata  <= 32'(m);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(m)) begin
			report_mismatch("channel_mode read back", prdata, 32'(m));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Stimulus.
	initial begin : sender
		int start;
		int stride;
		arst_n          = 1'b0;
		cmd_valid       = 1'b0;
		cmd_word        = '0;
		word_pinned     = 1'b0;
		word_pinned_res = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words in the reset mode, counting every byte. The core sweeps
		// its bins after reset; the first word simply waits for cmd_ready.
		// After reset every bin is zero, so a scan finds bin 0 both ways.
		dir_rows.push_back(row_pinned(mk_word(CMD_SCAN, 8'h00, 8'h00), '0));
		dir_rows.push_back(row_pinned(mk_word(CMD_READ, 8'h00, 8'h00), '0));
		dir_rows.push_back(row_pinned(mk_word(CMD_READ, 8'h00, 8'hFF), '0));
		dir_rows.push_back(row_pinned(mk_word(CMD_ADD, 8'hFF, 8'h00), '0));
		dir_rows.push_back(row_pinned(mk_word(CMD_ADD, 8'h00, 8'hFF), '0));
		dir_rows.push_back(row_pinned(mk_word(CMD_READ, 8'h00, 8'hFF),
			mk_res(32'd1, 8'd0, 32'd0, 8'd0, 32'd0)));
		// Bins 0 and 255 tie at one: the lowest index wins the maximum, and
		// bin 1 is the first empty one.
		dir_rows.push_back(row_pinned(mk_word(CMD_SCAN, 8'h00, 8'h00),
			mk_res(32'd0, 8'd0, 32'd1, 8'd1, 32'd0)));
		dir_rows.push_back(row_model(mk_word(CMD_ADD, 8'hFF, 8'h00)));
		dir_rows.push_back(row_model(mk_word(CMD_READ, 8'h00, 8'hFF)));
		dir_rows.push_back(row_pinned(mk_word(CMD_SCAN, 8'hFF, 8'hFF),
			mk_res(32'd0, 8'd255, 32'd2, 8'd1, 32'd0)));
		dir_rows.push_back(row_model(mk_word(CMD_ADD, 8'hAA, 8'h55)));
		dir_rows.push_back(row_model(mk_word(CMD_ADD, 8'h55, 8'hAA)));
		dir_rows.push_back(row_model(mk_word(CMD_READ, 8'h55, 8'hAA)));
		dir_rows.push_back(row_model(mk_word(CMD_READ, 8'hAA, 8'h55)));
		// Clear ignores its other fields and empties every bin.
		dir_rows.push_back(row_pinned(mk_word(CMD_CLEAR, 8'hFF, 8'hFF), '0));
		dir_rows.push_back(row_pinned(mk_word(CMD_READ, 8'h00, 8'hFF), '0));
		dir_rows.push_back(row_pinned(mk_word(CMD_SCAN, 8'h00, 8'h00), '0));
		dir_rows.push_back(row_model(mk_word(CMD_ADD, 8'h01, 8'h00)));
		dir_rows.push_back(row_model(mk_word(CMD_SCAN, 8'hFF, 8'hFF)));
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].result);
		end

		// Every byte value once, in a scrambled order (odd stride over 256), so
		// a later scan sees a minimum above zero; then random traffic.
		start  = $urandom_range(0, 255);
		stride = 2 * $urandom_range(0, 127) + 1;
		for (int i = 0; i < HIST_BINS; i++) begin
			send_word(mk_word(CMD_ADD, 8'(start + i * stride), 8'($urandom_range(0, 255))),
				1'b0, '0);
		end
		send_word(mk_word(CMD_SCAN, 8'h00, 8'h00), 1'b0, '0);
		run_random(44);

		// Blue only. Midway the sender stops until every result is back; the
		// long receiver hold-off also falls in this stretch.
		set_mode(MODE_BLUE);
		run_random(60);
		drain();
		run_random(60);

		set_mode(MODE_GREEN);
		run_random(120);

		set_mode(MODE_RED);
		run_random(120);

		// Last stretch back in the all-bytes mode, with no stalls on either side.
		set_mode(MODE_ALL);
		quiet = 1'b1;
		run_random(60);
		send_word(mk_word(CMD_SCAN, 8'h00, 8'h00), 1'b0, '0);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			report_mismatch("results never returned", pending_results.size(), 0);
		end
		$display("Covered %0d adds, %0d reads, %0d scans and %0d clears",
			n_by_cmd[CMD_ADD], n_by_cmd[CMD_READ], n_by_cmd[CMD_SCAN], n_by_cmd[CMD_CLEAR]);
		$display("across all four channel modes; %0d result words compared, %0d mismatches.",
			words_taken, n_errors);
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### sim.f
rtl/bhe_pkg.sv
rtl/bhe_ram.sv
rtl/bhe_fifo.sv
rtl/bhe_front.sv
rtl/bhe_back.sv
rtl/byte_histogram_with_extremes_core.sv
tb/sv/byte_histogram_with_extremes_core_test.sv
